[rtl/core/wto_pkg.sv]
// ----------------------------------------------------------------------------
// wto_pkg
// Shared types and constants of the wavetable oscillator: table geometry,
// function codes, register indexes and the command that the front part
// hands to the back part.
// ----------------------------------------------------------------------------
package wto_pkg;

    // table geometry
    localparam int NUM_TABLES = 10;
    localparam int TABLE_SIZE = 1024;
    localparam int FRAC_BITS  = 16;

    localparam int IDX_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int MEM_DEPTH = NUM_TABLES * TABLE_SIZE;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int TSEL_W    = 4;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_PW + 1;

    // request function codes
    typedef enum logic [1:0] {
        FUNC_SAMPLE    = 2'd0,
        FUNC_WRITE     = 2'd1,
        FUNC_SET_PHASE = 2'd2
    } t_func;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_PHASE_PER_FREQ = 1'b0,
        CFG_OCTAVE_SCALE   = 1'b1
    } t_cfg_idx;

    // classified command for the back part
    typedef struct packed {
        logic                      is_write;
        logic [TSEL_W-1:0]         octave;
        logic [31:0]               phase;
        logic [MEM_AW-1:0]         waddr;
        logic signed [15:0]        wval;
    } t_cmd;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[rtl/core/wto_front.sv]
// ----------------------------------------------------------------------------
// wto_front
// Accepts requests, holds the configuration registers and the phase
// accumulator, picks the octave table and queues sample and write commands.
// ----------------------------------------------------------------------------
module wto_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request side
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_func,
    input  logic [23:0]           i_frequency,
    input  logic [3:0]            i_table_select,
    input  logic [9:0]            i_table_addr,
    input  logic signed [15:0]    i_table_value,
    input  logic [31:0]           i_phase_value,
    // configuration writes
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    // command queue
    output logic                  o_q_push,
    output wto_pkg::t_cmd         o_q_cmd,
    input  wto_pkg::t_q_stat      i_q_stat
);
    import wto_pkg::*;

    // configuration registers
    logic [31:0] r_ppf;
    logic [15:0] r_oscale;

    // stage one registers
    logic                  r_f1_valid;
    logic [1:0]            r_f1_func;
    logic [55:0]           r_f1_inc_prod;
    logic [39:0]           r_f1_oct_prod;
    logic [MEM_AW-1:0]     r_f1_waddr;
    logic                  r_f1_wok;
    logic signed [15:0]    r_f1_wval;
    logic [31:0]           r_f1_phase_val;

    // phase accumulator
    logic [31:0] r_phase;

    logic              need_push;
    logic              stall;
    logic              accept;
    logic [TSEL_W-1:0] msb_m;
    logic [TSEL_W-1:0] octave;
    logic [MEM_AW-1:0] waddr_in;
    logic              wok_in;

    // configuration writes, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppf    <= 32'd22906492;
            r_oscale <= 16'd3277;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PHASE_PER_FREQ: r_ppf    <= i_cfg_data;
                CFG_OCTAVE_SCALE:   r_oscale <= i_cfg_data[15:0];
                default:            r_ppf    <= r_ppf;
            endcase
        end
    end

    // stall only when a command is waiting for a full queue
    always_comb begin
        need_push = r_f1_valid && ((r_f1_func == FUNC_SAMPLE) ||
                    ((r_f1_func == FUNC_WRITE) && r_f1_wok));
        stall     = need_push && i_q_stat.full;
        full      = stall;
        accept    = push && !stall;
        o_q_push  = need_push && !stall;
    end

    // write address and range check
    always_comb begin
        waddr_in = MEM_AW'(32'(i_table_select) * TABLE_SIZE + 32'(i_table_addr));
        wok_in   = (32'(i_table_select) < NUM_TABLES) &&
                   (32'(i_table_addr) < TABLE_SIZE);
    end

    // stage one: increment and octave products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (!stall) begin
            r_f1_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_func      <= i_func;
            r_f1_inc_prod  <= 56'(i_frequency) * 56'(r_ppf);
            r_f1_oct_prod  <= 40'(i_frequency) * 40'(r_oscale);
            r_f1_waddr     <= waddr_in;
            r_f1_wok       <= wok_in;
            r_f1_wval      <= i_table_value;
            r_f1_phase_val <= i_phase_value;
        end
    end

    // phase advances as each sample request leaves stage one; a set-phase request loads it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (r_f1_valid && !stall) begin
            case (r_f1_func)
                FUNC_SAMPLE:    r_phase <= r_phase + r_f1_inc_prod[47:16];
                FUNC_SET_PHASE: r_phase <= r_f1_phase_val;
                default:        r_phase <= r_phase;
            endcase
        end
    end

    // octave from the leading one of the scaled frequency
    always_comb begin
        msb_m = '0;
        for (int i = 25; i < 40; i++) begin
            if (r_f1_oct_prod[i]) begin
                msb_m = TSEL_W'(i - 24);
            end
        end
        if (32'(msb_m) > NUM_TABLES - 1) begin
            octave = TSEL_W'(NUM_TABLES - 1);
        end else begin
            octave = msb_m;
        end
    end

    // command toward the back part
    always_comb begin
        o_q_cmd.is_write = (r_f1_func == FUNC_WRITE);
        o_q_cmd.octave   = octave;
        o_q_cmd.phase    = r_phase;
        o_q_cmd.waddr    = r_f1_waddr;
        o_q_cmd.wval     = r_f1_wval;
    end

endmodule

[rtl/core/wto_queue.sv]
// ----------------------------------------------------------------------------
// wto_queue
// Short command queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module wto_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wto_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output wto_pkg::t_cmd     o_cmd,
    output wto_pkg::t_q_stat  o_stat
);
    import wto_pkg::*;

    t_cmd            r_buf [Q_DEPTH];
    logic [Q_PW-1:0] r_wr;
    logic [Q_PW-1:0] r_rd;
    logic [Q_CW-1:0] r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

    assign o_cmd        = r_buf[r_rd];
    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

[rtl/core/wto_back.sv]
// ----------------------------------------------------------------------------
// wto_back
// Carries out queued commands: table writes, the two-entry table read and
// the linear interpolation, ending in the result register.
// ----------------------------------------------------------------------------
module wto_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wto_pkg::t_cmd         i_cmd,
    input  wto_pkg::t_q_stat      i_q_stat,
    output logic                  o_q_pop,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output logic signed [15:0]    o_sample,
    output logic [3:0]            o_table_used
);
    import wto_pkg::*;

    localparam int POS_W = 32 + IDX_W;
    localparam int T_W   = 18 + FRAC_BITS;

    // table memory
    logic signed [15:0] r_mem [MEM_DEPTH];

    logic                     en;
    logic                     take;
    logic [POS_W-1:0]         pos;
    logic [IDX_W-1:0]         idx;
    logic [IDX_W-1:0]         nxt;
    logic [MEM_AW-1:0]        base;
    logic [MEM_AW-1:0]        addr_a;
    logic [MEM_AW-1:0]        addr_b;

    // stage one: table read
    logic                     r_v1;
    logic [TSEL_W-1:0]        r_oct1;
    logic [FRAC_BITS-1:0]     r_frac1;
    logic signed [15:0]       r_rd_a;
    logic signed [15:0]       r_rd_b;

    // stage two: weighted difference
    logic                     r_v2;
    logic [TSEL_W-1:0]        r_oct2;
    logic signed [15:0]       r_a2;
    logic signed [T_W-1:0]    r_t2;
    logic signed [16:0]       diff;
    logic signed [T_W-1:0]    n_t2;

    // stage three: result register
    logic                     r_v3;
    logic [TSEL_W-1:0]        r_oct3;
    logic signed [15:0]       r_sample;
    logic signed [T_W-1:0]    q;
    logic signed [T_W-1:0]    sum;

    // whole pipeline holds while an untaken result waits
    always_comb begin
        en      = !r_v3 || pop;
        take    = en && !i_q_stat.empty;
        o_q_pop = take;
    end

    // table position from the phase
    always_comb begin
        pos    = POS_W'(i_cmd.phase) * POS_W'(TABLE_SIZE);
        idx    = pos[POS_W-1:32];
        nxt    = (idx == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx + 1'b1;
        base   = MEM_AW'(i_cmd.octave) * MEM_AW'(TABLE_SIZE);
        addr_a = base + MEM_AW'(idx);
        addr_b = base + MEM_AW'(nxt);
    end

    // memory write port and two read ports
    always_ff @(posedge i_clk) begin
        if (take && i_cmd.is_write) begin
            r_mem[i_cmd.waddr] <= i_cmd.wval;
        end
        if (en) begin
            r_rd_a <= r_mem[addr_a];
            r_rd_b <= r_mem[addr_b];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= take && !i_cmd.is_write;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // interpolation arithmetic
    always_comb begin
        diff = {r_rd_b[15], r_rd_b} - {r_rd_a[15], r_rd_a};
        n_t2 = diff * $signed({1'b0, r_frac1});
        q    = r_t2 >>> FRAC_BITS;
        sum  = {{(T_W-16){r_a2[15]}}, r_a2} + q;
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oct1   <= i_cmd.octave;
            r_frac1  <= pos[31 -: FRAC_BITS];
            r_oct2   <= r_oct1;
            r_a2     <= r_rd_a;
            r_t2     <= n_t2;
            r_oct3   <= r_oct2;
            r_sample <= sum[15:0];
        end
    end

    assign empty        = !r_v3;
    assign o_sample     = r_sample;
    assign o_table_used = r_oct3;

endmodule

[rtl/core/wavetable_oscillator.sv]
// ----------------------------------------------------------------------------
// wavetable_oscillator
// Band-limited wavetable oscillator with per-octave tables and linear
// interpolation; a front part keeps phase and picks the table, a back part
// reads table memory and interpolates.
// Throughput: one request per cycle while neither side stalls, set by the
// single phase-add stage and the two-read table memory; a 4-entry command
// queue lets each side stall.
// Reset: synchronous, clears the phase, restores the configuration
// registers; table memory is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module wavetable_oscillator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request queue side
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_func,
    input  logic [23:0]           i_frequency,
    input  logic [3:0]            i_table_select,
    input  logic [9:0]            i_table_addr,
    input  logic signed [15:0]    i_table_value,
    input  logic [31:0]           i_phase_value,
    // result queue side
    output logic                  empty,
    input  logic                  pop,
    output logic signed [15:0]    o_sample,
    output logic [3:0]            o_table_used,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_idx,
    input  logic [31:0]           i_cfg_data
);
    import wto_pkg::*;

    logic    q_push;
    logic    q_pop;
    t_cmd    q_in;
    t_cmd    q_out;
    t_q_stat q_stat;

    assign o_cfg_ready = 1'b1;

    // front: accept and classify
    wto_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_frequency    (i_frequency),
        .i_table_select (i_table_select),
        .i_table_addr   (i_table_addr),
        .i_table_value  (i_table_value),
        .i_phase_value  (i_phase_value),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_q_push       (q_push),
        .o_q_cmd        (q_in),
        .i_q_stat       (q_stat)
    );

    // command queue
    wto_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_stat  (q_stat)
    );

    // back: memory and interpolation
    wto_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (q_out),
        .i_q_stat     (q_stat),
        .o_q_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_sample     (o_sample),
        .o_table_used (o_table_used)
    );

    // no command pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into full queue");

    // no command popped from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    // back part holds while a result waits untaken
    a_back_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |-> !q_pop)
        else $error("back part advanced behind a waiting result");

    // chosen table always exists
    a_table_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (32'(o_table_used) < NUM_TABLES))
        else $error("table number out of range");

endmodule

[dv/wavetable_oscillator_tb.sv]
// ----------------------------------------------------------------------------
// wavetable_oscillator_tb
// Self-checking bench for the wavetable oscillator. Requests go in through the
// push/full queue port and samples come out through the empty/pop port. Every
// accepted request updates a cycle-free copy of the phase and the table
// memory. That copy lists the sample and table each sample request
// must produce. Table words are loaded on demand so that no sample ever reads
// an entry that was never written. The run covers directed corner cases and
// then random traffic under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module wavetable_oscillator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wto_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int SEG_ITEMS      = 180;
    localparam int SEGMENTS       = 6;
    localparam int DRAIN_SETTLE   = 8;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [1:0]         func;
        logic [23:0]        freq;
        logic [3:0]         tsel;
        logic [9:0]         taddr;
        logic signed [15:0] tval;
        logic [31:0]        phase_val;
    } t_osc_req;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [3:0]         tbl;
    } t_osc_out;

    // oscillator state copy and queue of samples still owed by the block
    class sample_tracker;
        logic [31:0]        phase_acc = '0;
        logic [31:0]        ppf       = 32'd22906492;
        logic [15:0]        oct_scale = 16'd3277;
        logic signed [15:0] wave_mem [MEM_DEPTH];
        bit                 wave_loaded [MEM_DEPTH];
        t_osc_out           due_samples[$];
        int                 mismatches = 0;

        function void apply_cfg(t_cfg_idx idx, logic [31:0] data);
            if (idx == CFG_PHASE_PER_FREQ) begin
                ppf = data;
            end else begin
                oct_scale = data[15:0];
            end
        endfunction

        // octave from the msb of frequency times scale, clamped to the last table
        function int octave_of(logic [23:0] f);
            logic [39:0] prod;
            int          msb;
            prod = 40'(f) * 40'(oct_scale);
            if (prod < 40'h100_0000) return 0;
            msb = 39;
            while (!prod[msb]) msb--;
            return (msb - 24 > NUM_TABLES - 1) ? NUM_TABLES - 1 : msb - 24;
        endfunction

        // memory addresses of the two entries a sample at this frequency reads
        function void taps_of(logic [23:0] f, output int addr_a, output int addr_b);
            logic [63:0] pos;
            int          ia;
            int          ib;
            int          base;
            base = octave_of(f) * TABLE_SIZE;
            pos  = 64'(phase_acc) * 64'(TABLE_SIZE);
            ia   = int'(pos >> 32);
            if (ia >= TABLE_SIZE) ia = TABLE_SIZE - 1;
            ib = (ia + 1 >= TABLE_SIZE) ? 0 : ia + 1;
            addr_a = base + ia;
            addr_b = base + ib;
        endfunction

        function void note_request(t_osc_req r);
            int          aa;
            int          ab;
            int          waddr;
            longint      a;
            longint      b;
            longint      t;
            longint      frac;
            logic [63:0] pos;
            logic [55:0] step;
            t_osc_out    o;
            case (r.func)
                FUNC_SAMPLE: begin
                    // interpolate at the old phase, floor rounding on the slope
                    taps_of(r.freq, aa, ab);
                    pos  = 64'(phase_acc) * 64'(TABLE_SIZE);
                    frac = longint'((pos >> (32 - FRAC_BITS)) & ((64'd1 << FRAC_BITS) - 1));
                    a = wave_mem[aa];
                    b = wave_mem[ab];
                    t = (b - a) * frac;
                    o.sample = 16'(a + (t >>> FRAC_BITS));
                    o.tbl    = 4'(octave_of(r.freq));
                    due_samples.push_back(o);
                    step = 56'(r.freq) * 56'(ppf);
                    phase_acc = phase_acc + step[47:16];
                end
                FUNC_WRITE: begin
                    if (int'(r.tsel) < NUM_TABLES && int'(r.taddr) < TABLE_SIZE) begin
                        waddr = int'(r.tsel) * TABLE_SIZE + int'(r.taddr);
                        wave_mem[waddr]    = r.tval;
                        wave_loaded[waddr] = 1'b1;
                    end
                end
                FUNC_SET_PHASE: phase_acc = r.phase_val;
                default: ;
            endcase
        endfunction

        function void check_sample(logic signed [15:0] got_sample, logic [3:0] got_tbl);
            t_osc_out e;
            if (due_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected sample %0d table %0d", got_sample, got_tbl);
                return;
            end
            e = due_samples.pop_front();
            if (got_sample !== e.sample || got_tbl !== e.tbl) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: sample exp %0d got %0d, table exp %0d got %0d",
                             e.sample, got_sample, e.tbl, got_tbl);
            end
        endfunction

        function int pending();
            return due_samples.size();
        endfunction
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               push           = 1'b0;
    logic               full;
    logic [1:0]         i_func         = '0;
    logic [23:0]        i_frequency    = '0;
    logic [3:0]         i_table_select = '0;
    logic [9:0]         i_table_addr   = '0;
    logic signed [15:0] i_table_value  = '0;
    logic [31:0]        i_phase_value  = '0;
    logic               empty;
    logic               pop            = 1'b0;
    logic signed [15:0] o_sample;
    logic [3:0]         o_table_used;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_idx      = 1'b0;
    logic [31:0]        i_cfg_data     = '0;

    sample_tracker sb = new;

    int tx_idle_pct  = 38;
    int rx_idle_pct  = 83;
    int hold_cycles  = 0;
    bit hold_pending = 1'b0;
    int work_items   = 0;
    int quiet_cycles = 0;

    wavetable_oscillator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_frequency    (i_frequency),
        .i_table_select (i_table_select),
        .i_table_addr   (i_table_addr),
        .i_table_value  (i_table_value),
        .i_phase_value  (i_phase_value),
        .empty          (empty),
        .pop            (pop),
        .o_sample       (o_sample),
        .o_table_used   (o_table_used),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // result side: random pop with an optional long hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // sample check at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_sample(o_sample, o_table_used);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("wavetable_oscillator_tb NOT OK");
                    $finish;
                end
            end
        end
    end

    function automatic t_osc_req random_fields();
        t_osc_req r;
        r.func      = 2'($urandom);
        r.freq      = 24'($urandom);
        r.tsel      = 4'($urandom);
        r.taddr     = 10'($urandom);
        r.tval      = 16'($urandom);
        r.phase_val = $urandom;
        return r;
    endfunction

    // frequencies spread over all octaves, full width now and then
    function automatic logic [23:0] random_freq();
        int w;
        w = $urandom_range(0, 24);
        return 24'($urandom) & 24'((32'd1 << w) - 1);
    endfunction

    // one request, entered and left at a falling edge
    task automatic send_req(t_osc_req r);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push           <= 1'b1;
        i_func         <= r.func;
        i_frequency    <= r.freq;
        i_table_select <= r.tsel;
        i_table_addr   <= r.taddr;
        i_table_value  <= r.tval;
        i_phase_value  <= r.phase_val;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(r);
        if (r.func != FUNC_UNUSED && !(r.func == FUNC_WRITE && int'(r.tsel) >= NUM_TABLES))
            work_items++;
        if (hold_pending) begin
            hold_cycles  = RX_HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        @(negedge i_clk);
    endtask

    task automatic put_word(int sel, int addr, logic signed [15:0] v);
        t_osc_req r;
        r       = random_fields();
        r.func  = FUNC_WRITE;
        r.tsel  = 4'(sel);
        r.taddr = 10'(addr);
        r.tval  = v;
        send_req(r);
    endtask

    task automatic put_phase(logic [31:0] p);
        t_osc_req r;
        r           = random_fields();
        r.func      = FUNC_SET_PHASE;
        r.phase_val = p;
        send_req(r);
    endtask

    // load any unwritten entry the sample will read, then ask for the sample
    task automatic put_sample(logic [23:0] f);
        t_osc_req r;
        int       aa;
        int       ab;
        sb.taps_of(f, aa, ab);
        if (!sb.wave_loaded[aa]) put_word(aa / TABLE_SIZE, aa % TABLE_SIZE, 16'($urandom));
        if (!sb.wave_loaded[ab]) put_word(ab / TABLE_SIZE, ab % TABLE_SIZE, 16'($urandom));
        r      = random_fields();
        r.func = FUNC_SAMPLE;
        r.freq = f;
        send_req(r);
    endtask

    task automatic put_noise();
        t_osc_req r;
        r      = random_fields();
        r.func = FUNC_UNUSED;
        send_req(r);
    endtask

    task automatic rand_item();
        int          pick;
        logic [31:0] p;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            put_noise();
        end else if (pick < 10) begin
            p = $urandom;
            if ($urandom_range(0, 3) == 0) p[31 - $clog2(TABLE_SIZE):0] = '0;
            if ($urandom_range(0, 7) == 0) p = '1;
            put_phase(p);
        end else if (pick < 25) begin
            if ($urandom_range(0, 99) < 85)
                put_word($urandom_range(0, NUM_TABLES - 1), $urandom_range(0, TABLE_SIZE - 1),
                         16'($urandom));
            else
                put_word($urandom_range(NUM_TABLES, 15), $urandom_range(0, TABLE_SIZE - 1),
                         16'($urandom));
        end else begin
            put_sample(random_freq());
        end
    endtask

    // stop sending, let every sample arrive, then allow the pipe to settle
    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [31:0] ppf, logic [15:0] scale);
        i_cfg_valid <= 1'b1;
        i_cfg_idx   <= CFG_PHASE_PER_FREQ;
        i_cfg_data  <= ppf;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.apply_cfg(CFG_PHASE_PER_FREQ, ppf);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_OCTAVE_SCALE;
        i_cfg_data <= {16'h0, scale};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.apply_cfg(CFG_OCTAVE_SCALE, {16'h0, scale});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic idle_mode(int tx_pct, int rx_pct);
        @(posedge i_clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] seg_ppf [SEGMENTS];
        logic [15:0] seg_scale [SEGMENTS];
        int          seg_end;
        bit          hold_done;

        // register settings per segment, extremes included
        seg_ppf[0] = 32'd22906492;  seg_scale[0] = 16'd3277;
        seg_ppf[1] = 32'hFFFF_FFFF; seg_scale[1] = 16'hFFFF;
        seg_ppf[2] = $urandom;      seg_scale[2] = 16'($urandom);
        seg_ppf[3] = 32'h0;         seg_scale[3] = 16'h0;
        seg_ppf[4] = $urandom;      seg_scale[4] = 16'($urandom);
        seg_ppf[5] = 32'd1;         seg_scale[5] = 16'h8000;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners
        set_config(32'd22906492, 16'd3277);
        put_word(0, 0, 16'sh7FFF);
        put_word(0, 1, 16'sh8000);
        put_phase(32'h0);
        put_sample(24'h0);
        // steepest falling slope with the largest fraction
        put_phase(32'h003F_FFC0);
        put_sample(24'h0);
        // last entry wraps to the first
        put_word(0, TABLE_SIZE - 1, 16'sh8000);
        put_phase(32'hFFFF_FFFF);
        put_sample(24'h0);
        // writes to tables that do not exist must not land anywhere
        put_word(0, 5, 16'sd100);
        put_word(NUM_TABLES, 5, 16'sh8001);
        put_word(15, TABLE_SIZE - 1, 16'sh7FFF);
        put_phase(32'h0140_0000);
        put_sample(24'h0);
        put_noise();
        // octave boundaries and the clamp
        put_sample(24'd5119);
        put_sample(24'd5120);
        put_sample(24'd10240);
        put_sample(24'h80_0000);
        put_sample(24'hFF_FFFF);
        put_noise();

        // random segments under changing settings and idle patterns
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_drained();
            set_config(seg_ppf[seg], seg_scale[seg]);
            if (seg < 2) idle_mode(38, 83);
            else if (seg < 4) idle_mode(83, 38);
            else idle_mode(0, 0);
            seg_end   = work_items + SEG_ITEMS;
            hold_done = 1'b0;
            while (work_items < seg_end) begin
                if ((seg == 1 || seg == 4) && !hold_done &&
                    work_items >= seg_end - SEG_ITEMS / 2) begin
                    hold_pending = 1'b1;
                    hold_done    = 1'b1;
                end
                rand_item();
            end
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("wavetable_oscillator_tb OK");
        end else begin
            $display("wavetable_oscillator_tb NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/wto_pkg.sv
rtl/core/wto_front.sv
rtl/core/wto_queue.sv
rtl/core/wto_back.sv
rtl/core/wavetable_oscillator.sv
dv/wavetable_oscillator_tb.sv
